>>> rtl/thst_pkg.sv
package thst_pkg;

  localparam int unsigned GainW  = 11;
  localparam int unsigned TintW  = 9;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned CfgIdxW = 2;

  // gain * weight product and scale factor, both signed
  localparam int unsigned GkW  = 20;
  // (p - 128) * scale + bias
  localparam int unsigned NumW = 29;
  // quotient multiply width
  localparam int unsigned QuoW = 29;

  localparam logic [8:0]             TonePivot = 9'd204;
  // 256 * 204
  localparam logic signed [GkW-1:0]  ScaleOne  = 20'sd52224;
  // 128 * 256 * 204
  localparam logic signed [NumW-1:0] NumBias   = 29'sd6684672;
  // quotient of 256 or more
  localparam logic signed [NumW-1:0] NumHi     = 29'sd13369344;
  // quotient of -1 or less
  localparam logic signed [NumW-1:0] NumLo     = -29'sd52224;
  // ceil(2^20 / 51), exact for dividends below 2^14
  localparam logic [14:0]            Recip51   = 15'd20561;

  // register stages from input request to output register
  localparam int unsigned PipeDepth = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HIGHLIGHT = 2'd0,
    REG_SHADOW    = 2'd1,
    REG_TINT      = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_HIGHLIGHT = 1'b0,
    MODE_SHADOW    = 1'b1
  } tone_mode_e;

  // rgb[0] red, rgb[1] green, rgb[2] blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    rgb_t       rgb;
    logic [7:0] alpha;
    logic       frame_end;
  } pix_t;

endpackage

>>> rtl/thst_pix_if.sv
interface thst_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       frame_end;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output frame_end, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input frame_end, output ready);
endinterface

>>> rtl/thst_tone.sv
module thst_tone import thst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tone_mode_e              mode_i,
  input  logic signed [GainW-1:0] gain_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  pix_t                    pix_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output pix_t                    pix_o
);

  // stage valids and advance enables
  logic a_v_q, b_v_q, c_v_q, d_v_q;
  logic a_en, b_en, c_en, d_en;

  assign d_en    = !d_v_q || ready_i;
  assign c_en    = !c_v_q || d_en;
  assign b_en    = !b_v_q || c_en;
  assign a_en    = !a_v_q || b_en;
  assign ready_o = a_en;

  // stage A: max + min, weight, gain * weight
  logic [7:0]             mx, mn;
  logic [8:0]             s, k;
  logic signed [11:0]     g;
  logic signed [21:0]     gk_full;
  logic signed [GkW-1:0]  a_gk_d, a_gk_q;
  pix_t                   a_pix_q;

  always_comb begin
    mx = pix_i.rgb[0];
    mn = pix_i.rgb[0];
    for (int j = 1; j < 3; j++) begin
      if (pix_i.rgb[j] > mx) mx = pix_i.rgb[j];
      if (pix_i.rgb[j] < mn) mn = pix_i.rgb[j];
    end
    s = {1'b0, mx} + {1'b0, mn};
    if (mode_i == MODE_SHADOW) begin
      k = (s < TonePivot) ? TonePivot - s : 9'd0;
      g = -{gain_i[GainW-1], gain_i};
    end else begin
      k = (s > TonePivot) ? s - TonePivot : 9'd0;
      g = {gain_i[GainW-1], gain_i};
    end
    gk_full = 22'(g) * 22'($signed({1'b0, k}));
    a_gk_d  = gk_full[GkW-1:0];
  end

  // stage B: numerators per channel
  logic signed [GkW-1:0]      scale;
  logic signed [2:0][NumW-1:0] b_num_d, b_num_q;
  logic signed [8:0]          dlt;
  pix_t                       b_pix_q;

  always_comb begin
    scale = a_gk_q + ScaleOne;
    for (int j = 0; j < 3; j++) begin
      dlt        = $signed({1'b0, a_pix_q.rgb[j]}) - 9'sd128;
      b_num_d[j] = NumW'(dlt) * NumW'(scale) + NumBias;
    end
  end

  // stage C: saturation flags, quotient by 256 * 204 as shift plus reciprocal
  logic [2:0]               c_hi_d, c_hi_q, c_lo_d, c_lo_q;
  logic [2:0][QuoW-1:0]     c_quo_d, c_quo_q;
  logic [13:0]              x;
  pix_t                     c_pix_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      // elements of a packed array select as unsigned
      c_hi_d[j]  = $signed(b_num_q[j]) >= NumHi;
      c_lo_d[j]  = $signed(b_num_q[j]) <= NumLo;
      x          = b_num_q[j][NumW-1] ? 14'd0 : b_num_q[j][23:10];
      c_quo_d[j] = QuoW'(x) * QuoW'(Recip51);
    end
  end

  // stage D: first saturating channel in R, G, B order wins
  rgb_t d_rgb;
  logic stop;
  pix_t d_pix_q;

  always_comb begin
    stop = 1'b0;
    for (int j = 0; j < 3; j++) d_rgb[j] = c_quo_q[j][27:20];
    for (int j = 0; j < 3; j++) begin
      if (!stop) begin
        if (c_hi_q[j]) begin
          d_rgb = '1;
          stop  = 1'b1;
        end else if (c_lo_q[j]) begin
          d_rgb = '0;
          stop  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (a_en) a_v_q <= valid_i;
      if (b_en) b_v_q <= a_v_q;
      if (c_en) c_v_q <= b_v_q;
      if (d_en) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_gk_q  <= a_gk_d;
      a_pix_q <= pix_i;
    end
    if (b_en) begin
      b_num_q <= b_num_d;
      b_pix_q <= a_pix_q;
    end
    if (c_en) begin
      c_hi_q  <= c_hi_d;
      c_lo_q  <= c_lo_d;
      c_quo_q <= c_quo_d;
      c_pix_q <= b_pix_q;
    end
    if (d_en) begin
      d_pix_q <= '{rgb: d_rgb, alpha: c_pix_q.alpha, frame_end: c_pix_q.frame_end};
    end
  end

  assign valid_o = d_v_q;
  assign pix_o   = d_pix_q;

endmodule

>>> rtl/thst_tint.sv
module thst_tint import thst_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic signed [TintW-1:0] tint_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  pix_t                    pix_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output pix_t                    pix_o
);

  logic        v_q, en;
  pix_t        pix_d, pix_q;
  logic signed [9:0] sum;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    pix_d = pix_i;
    for (int j = 0; j < 3; j++) begin
      // green moves the other way
      if (j == 1) sum = $signed({2'b00, pix_i.rgb[j]}) - 10'(tint_i);
      else        sum = $signed({2'b00, pix_i.rgb[j]}) + 10'(tint_i);
      if (sum < 0)             pix_d.rgb[j] = 8'd0;
      else if (sum > 10'sd255) pix_d.rgb[j] = 8'd255;
      else                     pix_d.rgb[j] = sum[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pix_q <= pix_d;
  end

  assign valid_o = v_q;
  assign pix_o   = pix_q;

endmodule

>>> rtl/tone_highlight_shadow_tint_top.sv
// Highlight / shadow / tint pixel adjuster.
// Pixels arrive on pix_i and leave on pix_o, valid/ready channels; a request
// moves at a clock edge with valid and ready both high. Alpha and frame_end
// ride along untouched.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 highlight gain, 1 shadow gain, 2 tint); other indexes are dropped.
// Write only while no pixel is in flight.
// Pipeline: 9 register stages (4 per tone unit, 1 for tint): stages A to D of the
// highlight unit, then A to D of the shadow unit, then the tint output register.
// Throughput: one pixel per clock unless pix_o stalls, set by the stage chain;
// the multipliers in each tone unit are each fully pipelined.
// Stall: each stage advances when it is empty or the next one advances, so a
// held-off receiver freezes the output register and bubbles still close up;
// pix_i.ready drops only once every stage holds a pixel.
// Reset (rst_ni low, async): all stage valids clear, all gains and tint go to 0
// (identity). Pixel data registers are not reset.
module tone_highlight_shadow_tint_top import thst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  thst_pix_if.sink           pix_i,
  thst_pix_if.source         pix_o
);

  // configuration registers
  logic signed [GainW-1:0] hgain_d, hgain_q, sgain_d, sgain_q;
  logic signed [TintW-1:0] tint_d, tint_q;

  always_comb begin
    hgain_d = hgain_q;
    sgain_d = sgain_q;
    tint_d  = tint_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_HIGHLIGHT: hgain_d = cfg_wdata_i;
        REG_SHADOW:    sgain_d = cfg_wdata_i;
        REG_TINT:      tint_d  = cfg_wdata_i[TintW-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hgain_q <= '0;
      sgain_q <= '0;
      tint_q  <= '0;
    end else begin
      hgain_q <= hgain_d;
      sgain_q <= sgain_d;
      tint_q  <= tint_d;
    end
  end

  // input payload into the internal bundle
  pix_t in_pix;
  always_comb begin
    in_pix.rgb[0]    = pix_i.red;
    in_pix.rgb[1]    = pix_i.green;
    in_pix.rgb[2]    = pix_i.blue;
    in_pix.alpha     = pix_i.alpha;
    in_pix.frame_end = pix_i.frame_end;
  end

  logic hl_valid, hl_ready, sh_valid, sh_ready;
  pix_t hl_pix, sh_pix, out_pix;

  // highlights first
  thst_tone u_highlight (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (MODE_HIGHLIGHT),
    .gain_i  (hgain_q),
    .valid_i (pix_i.valid),
    .ready_o (pix_i.ready),
    .pix_i   (in_pix),
    .valid_o (hl_valid),
    .ready_i (hl_ready),
    .pix_o   (hl_pix)
  );

  // shadows see the highlight result, gain negated inside
  thst_tone u_shadow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (MODE_SHADOW),
    .gain_i  (sgain_q),
    .valid_i (hl_valid),
    .ready_o (hl_ready),
    .pix_i   (hl_pix),
    .valid_o (sh_valid),
    .ready_i (sh_ready),
    .pix_o   (sh_pix)
  );

  // tint stage doubles as the output register
  thst_tint u_tint (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tint_i  (tint_q),
    .valid_i (sh_valid),
    .ready_o (sh_ready),
    .pix_i   (sh_pix),
    .valid_o (pix_o.valid),
    .ready_i (pix_o.ready),
    .pix_o   (out_pix)
  );

  assign pix_o.red       = out_pix.rgb[0];
  assign pix_o.green     = out_pix.rgb[1];
  assign pix_o.blue      = out_pix.rgb[2];
  assign pix_o.alpha     = out_pix.alpha;
  assign pix_o.frame_end = out_pix.frame_end;

endmodule

>>> rtl/thst_checker.sv
module thst_checker import thst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [32:0] out_data_i
);

  localparam int unsigned CntW = $clog2(PipeDepth + 1);

  // requests in flight, as seen at the ports
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && !out_acc)      cnt_d = cnt_q + 1'b1;
    else if (!in_acc && out_acc) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeDepth))
    else $error("more requests in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result shown with nothing in flight");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> in_ready_i)
    else $error("empty pipeline refuses input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

endmodule

bind tone_highlight_shadow_tint_top thst_checker u_thst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  ({pix_o.red, pix_o.green, pix_o.blue, pix_o.alpha, pix_o.frame_end})
);
